// ===== rtl/core/rtrs_pkg.sv =====
// Shared types and constants of the remote-trip round sequencer.
package rtrs_pkg;

  localparam int unsigned ROUNDS = 8;
  localparam int unsigned ADDR_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ROUND_W = 3;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned POWER_W = 16;
  localparam int unsigned LTMR_W  = 9;
  localparam int unsigned STMR_W  = 10;
  localparam int unsigned STATE_W = 3;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  // minutes per half-hour code, seconds per alarm minute, post-trip wait
  localparam logic [LTMR_W-1:0] LimitMinPerCode = LTMR_W'(30);
  localparam logic [STMR_W-1:0] AlarmSecPerCode = STMR_W'(60);
  localparam logic [STMR_W-1:0] TripWaitSec     = STMR_W'(120);

  typedef enum logic [CMD_W-1:0] {
    CMD_TRIP    = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_SCAN    = 3'd2,
    CMD_SEC     = 3'd3,
    CMD_MIN     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_NEW    = 2'd1,
    MARK_ACTIVE = 2'd2
  } mark_e;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_ARMED   = 3'd1,
    ST_ALARM   = 3'd2,
    ST_PREPARE = 3'd3,
    ST_WAIT    = 3'd4,
    ST_DONE    = 3'd5
  } round_st_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RMW,
    FSM_SW_RD,
    FSM_SW_WR
  } fsm_e;

  // one RAM entry per round
  typedef struct packed {
    logic [1:0]         mark;
    logic [CODE_W-1:0]  limit_code;
    logic [CODE_W-1:0]  alarm_code;
    logic [LTMR_W-1:0]  limit_tmr;
    logic [STMR_W-1:0]  sec_tmr;
    logic [STATE_W-1:0] state;
    logic [POWER_W-1:0] trip_power;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ROUND_W-1:0] round;
    logic [CODE_W-1:0]  limit;
    logic [CODE_W-1:0]  alarm;
    logic [POWER_W-1:0] power;
  } req_t;

endpackage

// ===== rtl/core/rtrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rtrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/remote_trip_round_sequencer.sv =====
// Top level of the remote-trip round sequencer.
//
// Per-round sequencer for load-control rounds. Every request carries a
// command in s_axis_tuser: trip (stores the limit and alarm codes and marks
// a new command), release (drops the command), scan (runs one step of the
// round: idle, armed, alarm delay, trip prepare, tripped wait, done),
// second tick and minute tick (count every round's second timer or limit
// timer down to zero). Each request gives exactly one result on m_axis with
// the round's state and captured trip power after the request. The state of
// all rounds lives in one RAM with one entry per round; a per-entry valid
// bit, cleared by reset, makes an unwritten entry read as all zero, so no
// clearing pass follows reset. A trip, release or scan command is accepted
// with its RAM read, then modified, written back and answered; a tick or
// unknown command is answered without write-back, and a tick then sweeps
// the timers through the single RAM port pair, reading and writing back
// one entry after another. Only one request is in flight; s_axis_tready is
// high while no request is at work. The result sits in an output register,
// so a stalled m_axis holds only the next request's write-back. protect_mode
// may be written only while the block is idle; nonzero forces every scanned
// round to idle without touching its command.
module remote_trip_round_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // protect_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // round[2:0], limit_half_hours[6:3],
                                       // alarm_minutes[10:7], total_power[26:11]
  input  logic [2:0]  s_axis_tuser,    // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata     // out_round[2:0], round_state[5:3],
                                       // trip_counted[6], record_event[7],
                                       // power_at_trip[23:8], power_after[39:24]
);

  localparam int unsigned AW = rtrs_pkg::ADDR_W;
  localparam int unsigned LTMR = rtrs_pkg::LTMR_W;
  localparam int unsigned STMR = rtrs_pkg::STMR_W;

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  rtrs_pkg::fsm_e   fsm_q, fsm_d;
  rtrs_pkg::req_t   req_q, req_d;
  logic [1:0]       protect_q;
  logic [AW-1:0]    idx_q, idx_d;
  logic [rtrs_pkg::ROUNDS-1:0] vld_q;
  logic             rd_vld_q;
  logic             out_vld_q, out_vld_d;
  logic [rtrs_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // control
  logic             s_acc;
  logic             out_free;
  logic             ram_re, ram_we;
  logic [AW-1:0]    ram_raddr, ram_waddr;
  logic [rtrs_pkg::ENTRY_W-1:0] ram_rdata, ram_wdata;
  logic             load_out;

  // datapath
  rtrs_pkg::entry_t rd_ent, upd_ent, sw_ent;
  logic             round_ok;
  logic             counted, event_hit;
  logic             upd_we;
  logic             is_tick;

  assign s_acc    = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_vld_q | m_axis_tready;
  assign round_ok = 5'(req_q.round) < 5'(rtrs_pkg::ROUNDS);
  assign is_tick  = (req_q.cmd == rtrs_pkg::CMD_SEC) || (req_q.cmd == rtrs_pkg::CMD_MIN);

  // unwritten entries read as the reset value
  assign rd_ent = rd_vld_q ? rtrs_pkg::entry_t'(ram_rdata) : '0;

  // ---------------------------------------------------------------------
  // request step: trip / release / scan on the addressed round
  // ---------------------------------------------------------------------
  always_comb begin
    upd_ent   = rd_ent;
    counted   = 1'b0;
    event_hit = 1'b0;
    upd_we    = 1'b0;
    case (req_q.cmd)
      rtrs_pkg::CMD_TRIP: begin
        upd_ent.limit_code = req_q.limit;
        upd_ent.alarm_code = req_q.alarm;
        upd_ent.mark       = rtrs_pkg::MARK_NEW;
        upd_we             = round_ok;
      end
      rtrs_pkg::CMD_RELEASE: begin
        upd_ent.mark = rtrs_pkg::MARK_NONE;
        upd_we       = round_ok;
      end
      rtrs_pkg::CMD_SCAN: begin
        upd_we = round_ok;
        if (protect_q != 2'd0) begin
          upd_ent.state = rtrs_pkg::ST_IDLE;
        end else if (rd_ent.mark == rtrs_pkg::MARK_NEW) begin
          upd_ent.limit_tmr = LTMR'(rd_ent.limit_code) * rtrs_pkg::LimitMinPerCode;
          upd_ent.mark      = rtrs_pkg::MARK_ACTIVE;
          upd_ent.state     = rtrs_pkg::ST_ARMED;
        end else if (rd_ent.mark != rtrs_pkg::MARK_ACTIVE) begin
          upd_ent.state = rtrs_pkg::ST_IDLE;
        end else if (rd_ent.limit_code != '0 && rd_ent.limit_tmr == '0) begin
          // limit ran out: cancel the round
          upd_ent.mark  = rtrs_pkg::MARK_NONE;
          upd_ent.state = rtrs_pkg::ST_IDLE;
        end else begin
          case (rd_ent.state)
            rtrs_pkg::ST_IDLE: begin
              upd_ent.state = rtrs_pkg::ST_ARMED;
            end
            rtrs_pkg::ST_ARMED: begin
              if (rd_ent.alarm_code == '0) begin
                upd_ent.state = rtrs_pkg::ST_PREPARE;
              end else begin
                upd_ent.sec_tmr = STMR'(rd_ent.alarm_code) * rtrs_pkg::AlarmSecPerCode;
                upd_ent.state   = rtrs_pkg::ST_ALARM;
              end
            end
            rtrs_pkg::ST_ALARM: begin
              if (rd_ent.sec_tmr == '0) begin
                upd_ent.state = rtrs_pkg::ST_PREPARE;
              end
            end
            rtrs_pkg::ST_PREPARE: begin
              upd_ent.trip_power = req_q.power;
              upd_ent.sec_tmr    = rtrs_pkg::TripWaitSec;
              upd_ent.state      = rtrs_pkg::ST_WAIT;
              counted            = 1'b1;
            end
            rtrs_pkg::ST_WAIT: begin
              if (rd_ent.sec_tmr == '0) begin
                upd_ent.state = rtrs_pkg::ST_DONE;
                event_hit     = 1'b1;
              end
            end
            rtrs_pkg::ST_DONE: begin
              upd_ent.state = rtrs_pkg::ST_DONE;
            end
            default: begin
              upd_ent.state = rtrs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  // tick sweep: count one timer of the entry down, saturating at zero
  always_comb begin
    sw_ent = rd_ent;
    if (req_q.cmd == rtrs_pkg::CMD_SEC) begin
      if (rd_ent.sec_tmr != '0) begin
        sw_ent.sec_tmr = rd_ent.sec_tmr - STMR'(1);
      end
    end else begin
      if (rd_ent.limit_tmr != '0) begin
        sw_ent.limit_tmr = rd_ent.limit_tmr - LTMR'(1);
      end
    end
  end

  // result word
  always_comb begin
    out_data_d = out_data_q;
    if (load_out) begin
      out_data_d = {
        (event_hit ? req_q.power : {rtrs_pkg::POWER_W{1'b0}}),
        (round_ok ? upd_ent.trip_power : {rtrs_pkg::POWER_W{1'b0}}),
        event_hit,
        counted,
        (round_ok ? upd_ent.state : {rtrs_pkg::STATE_W{1'b0}}),
        req_q.round
      };
    end
  end

  // ---------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    fsm_d = fsm_q;
    idx_d = idx_q;
    case (fsm_q)
      rtrs_pkg::FSM_IDLE: begin
        if (s_acc) begin
          fsm_d = rtrs_pkg::FSM_RMW;
        end
      end
      rtrs_pkg::FSM_RMW: begin
        if (out_free) begin
          if (is_tick) begin
            fsm_d = rtrs_pkg::FSM_SW_RD;
            idx_d = '0;
          end else begin
            fsm_d = rtrs_pkg::FSM_IDLE;
          end
        end
      end
      rtrs_pkg::FSM_SW_RD: begin
        fsm_d = rtrs_pkg::FSM_SW_WR;
      end
      rtrs_pkg::FSM_SW_WR: begin
        if (idx_q == AW'(rtrs_pkg::ROUNDS - 1)) begin
          fsm_d = rtrs_pkg::FSM_IDLE;
        end else begin
          fsm_d = rtrs_pkg::FSM_SW_RD;
          idx_d = idx_q + AW'(1);
        end
      end
      default: begin
        fsm_d = rtrs_pkg::FSM_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = AW'(s_axis_tdata[rtrs_pkg::ROUND_W-1:0]);
    ram_we        = 1'b0;
    ram_waddr     = AW'(req_q.round);
    ram_wdata     = upd_ent;
    load_out      = 1'b0;
    case (fsm_q)
      rtrs_pkg::FSM_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_acc;
      end
      rtrs_pkg::FSM_RMW: begin
        // write-back waits with the result for a free output register
        load_out = out_free;
        ram_we   = out_free & upd_we;
      end
      rtrs_pkg::FSM_SW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      rtrs_pkg::FSM_SW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = sw_ent;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    req_d = req_q;
    if (s_acc) begin
      req_d.cmd   = s_axis_tuser;
      req_d.round = s_axis_tdata[2:0];
      req_d.limit = s_axis_tdata[6:3];
      req_d.alarm = s_axis_tdata[10:7];
      req_d.power = s_axis_tdata[26:11];
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= rtrs_pkg::FSM_IDLE;
      idx_q     <= '0;
      protect_q <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      fsm_q     <= fsm_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        protect_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_data_q <= out_data_d;
  end

  rtrs_ram #(
    .Width (rtrs_pkg::ENTRY_W),
    .Depth (rtrs_pkg::ROUNDS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
